// ===== rtl/core/rsi_pkg.sv =====
package rsi_pkg;

   localparam int COORD_W      = 32;
   localparam int DIR_W        = 16;
   localparam int RAD_W        = 31;
   localparam int DIST_W       = 32;
   localparam int OE_W         = COORD_W + 1;
   localparam int PROD_W       = OE_W + DIR_W;
   localparam int SQ_W         = 2 * COORD_W;
   localparam int OE2_W        = SQ_W + 2;
   localparam int R2_W         = 2 * RAD_W;
   localparam int V_W          = PROD_W + 2;
   localparam int VPOS_W       = V_W - 1;
   localparam int HALF_W       = VPOS_W / 2;
   localparam int DIFF_W       = OE2_W + 1;
   localparam int VSQ_W        = 4 * HALF_W;
   localparam int D2_SHIFT     = 28;
   localparam int D2_W         = 104;
   localparam int ROOT_W       = 51;
   localparam int OPND_W       = 2 * ROOT_W;
   localparam int REM_W        = ROOT_W + 3;
   localparam int FRAC_SHIFT   = 14;
   localparam int DIST_DW      = ROOT_W + 2;
   localparam int FRONT_STAGES = 6;

   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [DIR_W-1:0]   dir_x;
      logic signed [DIR_W-1:0]   dir_y;
      logic signed [DIR_W-1:0]   dir_z;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [RAD_W-1:0]          radius;
   } req_payload_type;

   typedef struct packed {
      logic                     hit;
      logic signed [DIST_W-1:0] distance;
   } rsp_payload_type;

   typedef struct packed {
      logic              miss;
      logic [VPOS_W-1:0] v;
      logic [OPND_W-1:0] d2;
   } q_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// ===== rtl/core/rsi_stream_if.sv =====
interface rsi_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/rsi_front.sv =====
module rsi_front
   import rsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   rsi_stream_if.sink   req,
   input  q_status_type q_status,
   output logic         push,
   output q_entry_type  entry
);

   logic [FRONT_STAGES-1:0] vld_ff, vld_in;
   logic                    en;

   logic signed [OE_W-1:0]   oe_ff [3], oe_in [3];
   logic signed [DIR_W-1:0]  dir_ff [3], dir_in [3];
   logic [RAD_W-1:0]         rad_ff, rad_in;

   logic signed [PROD_W-1:0] pv_ff [3], pv_in [3];
   logic signed [2*OE_W-1:0] sq_full [3];
   logic [SQ_W-1:0]          sq_ff [3], sq_in [3];
   logic [R2_W-1:0]          r2_ff, r2_in;

   logic signed [V_W-1:0]    v3_ff, v3_in;
   logic [OE2_W-1:0]         oe2_ff, oe2_in;
   logic [R2_W-1:0]          r2b_ff, r2b_in;

   logic [HALF_W-1:0]        vh, vl;
   logic [2*HALF_W-1:0]      vhh_ff, vhh_in, vhl_ff, vhl_in, vll_ff, vll_in;
   logic signed [DIFF_W-1:0] diff4_ff, diff4_in;
   logic [VPOS_W-1:0]        v4_ff, v4_in;
   logic                     vmiss4_ff, vmiss4_in;

   logic [VSQ_W-1:0]         vsq5_ff, vsq5_in;
   logic signed [DIFF_W-1:0] diff5_ff, diff5_in;
   logic [VPOS_W-1:0]        v5_ff, v5_in;
   logic                     vmiss5_ff, vmiss5_in;

   logic signed [D2_W-1:0]   d2_ff, d2_in;
   logic [VPOS_W-1:0]        v6_ff, v6_in;
   logic                     vmiss6_ff, vmiss6_in;

   assign en        = !(vld_ff[FRONT_STAGES-1] && q_status.full);
   assign req.ready = en;
   assign push      = vld_ff[FRONT_STAGES-1] && !q_status.full;
   assign vld_in    = en ? {vld_ff[FRONT_STAGES-2:0], req.valid} : vld_ff;

   // offsets from origin to center
   always_comb begin
      oe_in[0]  = $signed({req.payload.center_x[COORD_W-1], req.payload.center_x})
                - $signed({req.payload.origin_x[COORD_W-1], req.payload.origin_x});
      oe_in[1]  = $signed({req.payload.center_y[COORD_W-1], req.payload.center_y})
                - $signed({req.payload.origin_y[COORD_W-1], req.payload.origin_y});
      oe_in[2]  = $signed({req.payload.center_z[COORD_W-1], req.payload.center_z})
                - $signed({req.payload.origin_z[COORD_W-1], req.payload.origin_z});
      dir_in[0] = req.payload.dir_x;
      dir_in[1] = req.payload.dir_y;
      dir_in[2] = req.payload.dir_z;
      rad_in    = req.payload.radius;
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         pv_in[i]   = oe_ff[i] * dir_ff[i];
         sq_full[i] = oe_ff[i] * oe_ff[i];
         sq_in[i]   = sq_full[i][SQ_W-1:0];
      end
      r2_in = rad_ff * rad_ff;
   end

   always_comb begin
      v3_in  = V_W'(pv_ff[0]) + V_W'(pv_ff[1]) + V_W'(pv_ff[2]);
      oe2_in = OE2_W'(sq_ff[0]) + OE2_W'(sq_ff[1]) + OE2_W'(sq_ff[2]);
      r2b_in = r2_ff;
   end

   // v squared split into halves to keep the multipliers narrow
   always_comb begin
      vh        = v3_ff[2*HALF_W-1:HALF_W];
      vl        = v3_ff[HALF_W-1:0];
      vhh_in    = vh * vh;
      vhl_in    = vh * vl;
      vll_in    = vl * vl;
      diff4_in  = $signed({{(DIFF_W-R2_W){1'b0}}, r2b_ff})
                - $signed({{(DIFF_W-OE2_W){1'b0}}, oe2_ff});
      v4_in     = v3_ff[VPOS_W-1:0];
      vmiss4_in = v3_ff[V_W-1];
   end

   always_comb begin
      vsq5_in   = {vhh_ff, {(2*HALF_W){1'b0}}}
                + VSQ_W'({vhl_ff, {(HALF_W+1){1'b0}}})
                + VSQ_W'(vll_ff);
      diff5_in  = diff4_ff;
      v5_in     = v4_ff;
      vmiss5_in = vmiss4_ff;
   end

   always_comb begin
      d2_in     = D2_W'($signed({diff5_ff, {D2_SHIFT{1'b0}}})) + D2_W'(vsq5_ff);
      v6_in     = v5_ff;
      vmiss6_in = vmiss5_ff;
   end

   always_comb begin
      entry.miss = vmiss6_ff || d2_ff[D2_W-1];
      entry.v    = v6_ff;
      entry.d2   = d2_ff[OPND_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         oe_ff     <= oe_in;
         dir_ff    <= dir_in;
         rad_ff    <= rad_in;
         pv_ff     <= pv_in;
         sq_ff     <= sq_in;
         r2_ff     <= r2_in;
         v3_ff     <= v3_in;
         oe2_ff    <= oe2_in;
         r2b_ff    <= r2b_in;
         vhh_ff    <= vhh_in;
         vhl_ff    <= vhl_in;
         vll_ff    <= vll_in;
         diff4_ff  <= diff4_in;
         v4_ff     <= v4_in;
         vmiss4_ff <= vmiss4_in;
         vsq5_ff   <= vsq5_in;
         diff5_ff  <= diff5_in;
         v5_ff     <= v5_in;
         vmiss5_ff <= vmiss5_in;
         d2_ff     <= d2_in;
         v6_ff     <= v6_in;
         vmiss6_ff <= vmiss6_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_stall_keeps_beat: assert property (@(posedge clock) disable iff (reset)
      vld_ff[FRONT_STAGES-1] && q_status.full |=> vld_ff[FRONT_STAGES-1])
      else $error("front dropped a stalled beat");
`endif

endmodule

// ===== rtl/core/rsi_queue.sv =====
module rsi_queue
   import rsi_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  q_entry_type  wr_entry,
   input  logic         pop,
   output q_entry_type  head,
   output q_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   q_entry_type       mem_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign head         = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("queue read while empty");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> count_ff == $past(count_ff) + CNT_W'($past(push))
                                    - CNT_W'($past(pop)))
      else $error("queue count out of step");
`endif

endmodule

// ===== rtl/core/rsi_back.sv =====
module rsi_back
   import rsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  q_entry_type  head,
   input  q_status_type q_status,
   output logic         pop,
   rsi_stream_if.source rsp
);

   logic [REM_W-1:0]  rem_q  [ROOT_W+1];
   logic [ROOT_W-1:0] root_q [ROOT_W+1];
   logic [OPND_W-1:0] opnd_q [ROOT_W+1];
   logic [VPOS_W-1:0] v_q    [ROOT_W+1];
   logic              miss_q [ROOT_W+1];
   logic [ROOT_W:0]   vld_q;

   logic              en;
   logic              out_vld_ff, out_vld_in;
   rsp_payload_type   out_ff, out_in;

   logic signed [DIST_DW-1:0] dist_full, dist_q;

   assign en  = !(out_vld_ff && !rsp.ready);
   assign pop = en && !q_status.empty;

   // one root bit per stage, restoring digit recurrence
   for (genvar k = 0; k <= ROOT_W; k++) begin : g_stage
      logic [REM_W-1:0]  rem_ff, rem_in;
      logic [ROOT_W-1:0] root_ff, root_in;
      logic [OPND_W-1:0] opnd_ff, opnd_in;
      logic [VPOS_W-1:0] v_ff, v_in;
      logic              miss_ff, miss_in;
      logic              vld_ff, vld_in;

      if (k == 0) begin : g_load
         always_comb begin
            rem_in  = '0;
            root_in = '0;
            opnd_in = head.d2;
            v_in    = head.v;
            miss_in = head.miss;
            vld_in  = en ? pop : vld_ff;
         end
      end else begin : g_step
         logic [REM_W-1:0] rem_t, trial;
         always_comb begin
            rem_t   = {rem_q[k-1][REM_W-3:0], opnd_q[k-1][OPND_W-1 -: 2]};
            trial   = {1'b0, root_q[k-1], 2'b01};
            if (rem_t >= trial) begin
               rem_in  = rem_t - trial;
               root_in = {root_q[k-1][ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_t;
               root_in = {root_q[k-1][ROOT_W-2:0], 1'b0};
            end
            opnd_in = {opnd_q[k-1][OPND_W-3:0], 2'b00};
            v_in    = v_q[k-1];
            miss_in = miss_q[k-1];
            vld_in  = en ? vld_q[k-1] : vld_ff;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            opnd_ff <= opnd_in;
            v_ff    <= v_in;
            miss_ff <= miss_in;
         end
      end

      assign rem_q[k]  = rem_ff;
      assign root_q[k] = root_ff;
      assign opnd_q[k] = opnd_ff;
      assign v_q[k]    = v_ff;
      assign miss_q[k] = miss_ff;
      assign vld_q[k]  = vld_ff;
   end

   // floor to q16.16 then saturate, zero on a miss
   always_comb begin
      dist_full = $signed({{(DIST_DW-VPOS_W){1'b0}}, v_q[ROOT_W]})
                - $signed({{(DIST_DW-ROOT_W){1'b0}}, root_q[ROOT_W]});
      dist_q    = dist_full >>> FRAC_SHIFT;
      out_in.hit = !miss_q[ROOT_W];
      if (miss_q[ROOT_W]) begin
         out_in.distance = '0;
      end else if ((&dist_q[DIST_DW-1:DIST_W-1]) || !(|dist_q[DIST_DW-1:DIST_W-1])) begin
         out_in.distance = dist_q[DIST_W-1:0];
      end else if (dist_q[DIST_DW-1]) begin
         out_in.distance = {1'b1, {(DIST_W-1){1'b0}}};
      end else begin
         out_in.distance = {1'b0, {(DIST_W-1){1'b1}}};
      end
      out_vld_in = en ? vld_q[ROOT_W] : out_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;

`ifndef NO_ASSERTIONS
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !out_ff.hit |-> out_ff.distance == '0)
      else $error("miss beat carries a distance");
`endif

endmodule

// ===== rtl/core/ray_sphere_intersect.sv =====
// path: req beat -> front pipeline -> queue -> square root pipeline -> rsp beat
// throughput: one beat per cycle while rsp_chan is ready
// depth is set mostly by the square root pipeline: a load stage, then one root bit per stage
// reset: synchronous, clears all valid flags and empties the queue
module ray_sphere_intersect
   import rsi_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   rsi_stream_if.sink   req_chan,
   rsi_stream_if.source rsp_chan
);

   logic         push, pop;
   q_entry_type  wr_entry, head;
   q_status_type q_status;

   rsi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_chan),
      .q_status (q_status),
      .push     (push),
      .entry    (wr_entry)
   );

   rsi_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .wr_entry (wr_entry),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   rsi_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

// ===== tb/tb_ray_sphere_intersect.sv =====
module tb_ray_sphere_intersect;
   import rsi_pkg::*;

   localparam int LATENCY = 59;
   localparam int N_RANDOM = 1000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rsi_stream_if #(.payload_type(req_payload_type)) req_chan ();
   rsi_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();

   ray_sphere_intersect u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   always #5 clock = ~clock;

   rsp_payload_type hit_queue[$];
   int unsigned     mismatches = 0;
   int unsigned     beats_in = 0;
   int unsigned     beats_out = 0;
   int unsigned     hits_seen = 0;
   bit              stim_done = 1'b0;
   bit              long_hold = 1'b0;
   bit              hold_done = 1'b0;

   // exact integer root of a 128-bit value, one bit at a time
   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0]  root;
      logic [63:0]  cand;
      logic [127:0] sq;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = root | (64'd1 << b);
         sq = {64'd0, cand} * {64'd0, cand};
         if (sq <= n) root = cand;
      end
      return root;
   endfunction

   function automatic rsp_payload_type trace_ray(req_payload_type r);
      rsp_payload_type     res;
      logic signed [63:0]  oe[3];
      logic signed [63:0]  proj;
      logic signed [127:0] oe_sq;
      logic signed [127:0] disc;
      logic signed [63:0]  delta;
      logic signed [63:0]  q;
      logic [63:0]         root;
      oe[0] = 64'(r.center_x) - 64'(r.origin_x);
      oe[1] = 64'(r.center_y) - 64'(r.origin_y);
      oe[2] = 64'(r.center_z) - 64'(r.origin_z);
      proj = oe[0] * 64'(r.dir_x) + oe[1] * 64'(r.dir_y) + oe[2] * 64'(r.dir_z);
      res = '0;
      if (proj < 0) return res;
      oe_sq = 128'(oe[0]) * 128'(oe[0]) + 128'(oe[1]) * 128'(oe[1])
            + 128'(oe[2]) * 128'(oe[2]);
      disc = ((128'(signed'({1'b0, r.radius})) * 128'(signed'({1'b0, r.radius})))
             <<< 28) - (oe_sq <<< 28) + 128'(proj) * 128'(proj);
      if (disc < 0) return res;
      root = isqrt(disc);
      delta = proj - signed'(root);
      q = delta >>> 14;   // floor toward minus infinity
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      res.hit = 1'b1;
      res.distance = q[31:0];
      return res;
   endfunction

   function automatic int unsigned gap_len();
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
      return 0;
   endfunction

   task automatic send_ray(req_payload_type r);
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
      hit_queue.push_back(trace_ray(r));
      beats_in++;
      @(negedge clock);
   endtask

   task automatic idle_req();
      int unsigned n;
      n = gap_len();
      if (n != 0) begin
         req_chan.valid <= 1'b0;
         repeat (n) @(negedge clock);
      end
   endtask

   function automatic logic signed [31:0] rnd_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'(signed'($urandom_range(0, 20 << 16)) - (10 << 16));
         2: return ($urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000);
         default: return 32'(signed'($urandom_range(0, 2000 << 16)) - (1000 << 16));
      endcase
   endfunction

   function automatic req_payload_type rnd_ray();
      req_payload_type r;
      r.origin_x = rnd_coord();
      r.origin_y = rnd_coord();
      r.origin_z = rnd_coord();
      r.center_x = rnd_coord();
      r.center_y = rnd_coord();
      r.center_z = rnd_coord();
      r.dir_x = 16'($urandom);
      r.dir_y = 16'($urandom);
      r.dir_z = 16'($urandom);
      case ($urandom_range(0, 3))
         0: r.radius = 31'($urandom);
         1: r.radius = 31'h7fffffff;
         default: r.radius = 31'($urandom_range(0, 1000 << 16));
      endcase
      // aim roughly at the centre half the time so that hits are common
      if ($urandom_range(0, 1)) begin
         r.origin_x = r.center_x - 32'(signed'($urandom_range(0, 200 << 16)));
         r.origin_y = r.center_y + 32'(signed'($urandom_range(0, 4 << 16)) - (2 << 16));
         r.origin_z = r.center_z + 32'(signed'($urandom_range(0, 4 << 16)) - (2 << 16));
         r.dir_x = 16'sd16384 - 16'(signed'($urandom_range(0, 300)));
         r.dir_y = 16'(signed'($urandom_range(0, 600)) - 300);
         r.dir_z = 16'(signed'($urandom_range(0, 600)) - 300);
         r.radius = 31'($urandom_range(1 << 16, 50 << 16));
      end
      return r;
   endfunction

   typedef struct {
      req_payload_type ray;
      bit              known;
      rsp_payload_type want;
   } stim_row_type;

   function automatic req_payload_type mk(int ox, int oy, int oz, int dx, int dy, int dz,
                                          int cx, int cy, int cz, int rad);
      req_payload_type r;
      r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
      r.dir_x = 16'(dx); r.dir_y = 16'(dy); r.dir_z = 16'(dz);
      r.center_x = cx; r.center_y = cy; r.center_z = cz;
      r.radius = 31'(rad);
      return r;
   endfunction

   localparam int ONE = 1 << 16;
   localparam int DONE = 1 << 14;

   initial begin
      stim_row_type rows[$];
      rsp_payload_type miss;
      rsp_payload_type hit10;
      rsp_payload_type hit0;
      miss = '0;
      hit10 = '{hit: 1'b1, distance: 8 * ONE};
      hit0 = '{hit: 1'b1, distance: 0};
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      // sphere behind the ray
      rows.push_back('{mk(0,0,0, DONE,0,0, -10*ONE,0,0, 2*ONE), 1, miss});
      // straight hit at distance 8
      rows.push_back('{mk(0,0,0, DONE,0,0, 10*ONE,0,0, 2*ONE), 1, hit10});
      // zero projection, origin on the surface
      rows.push_back('{mk(0,0,0, 0,DONE,0, 2*ONE,0,0, 2*ONE), 1, hit0});
      // zero projection, outside: miss
      rows.push_back('{mk(0,0,0, 0,DONE,0, 5*ONE,0,0, 2*ONE), 1, miss});
      // tangent ray
      rows.push_back('{mk(0,0,0, DONE,0,0, 10*ONE,2*ONE,0, 2*ONE), 1,
                       '{hit: 1'b1, distance: 10*ONE}});
      // passes beside the sphere
      rows.push_back('{mk(0,0,0, DONE,0,0, 10*ONE,3*ONE,0, 2*ONE), 1, miss});
      // origin inside: negative distance
      rows.push_back('{mk(0,0,0, DONE,0,0, ONE,0,0, 4*ONE), 1,
                       '{hit: 1'b1, distance: -3*ONE}});
      // zero radius, zero direction
      rows.push_back('{mk(0,0,0, 0,0,0, 0,0,0, 0), 1, hit0});
      rows.push_back('{mk(0,0,0, 0,0,0, ONE,0,0, 0), 1, miss});
      // non-unit direction and extremes
      rows.push_back('{mk(0,0,0, 32767,32767,32767, 10*ONE,10*ONE,10*ONE, ONE), 0, miss});
      rows.push_back('{mk(0,0,0, -32768,-32768,-32768, -10*ONE,-5*ONE,-ONE, 3*ONE),
                       0, miss});
      rows.push_back('{mk(32'h80000000,32'h80000000,32'h80000000, 32767,32767,32767,
                          32'h7fffffff,32'h7fffffff,32'h7fffffff, 32'h7fffffff), 0, miss});
      rows.push_back('{mk(32'h7fffffff,32'h7fffffff,32'h7fffffff, -32768,-32768,-32768,
                          32'h80000000,32'h80000000,32'h80000000, 32'h7fffffff), 0, miss});
      rows.push_back('{mk(32'h80000000,0,0, 32767,0,0, 32'h7fffffff,0,0, 0), 0, miss});
      rows.push_back('{mk(32'h7fffffff,0,0, 0,0,0, 32'h80000000,0,0, 32'h7fffffff),
                       0, miss});
      rows.push_back('{mk(-1,-1,-1, 1,1,1, 1,1,1, 1), 0, miss});
      rows.push_back('{mk(32'h55555555,32'haaaaaaaa,32'h0f0f0f0f, 16'h5555,16'haaaa,16'h0f0f,
                          32'haaaaaaaa,32'h55555555,32'hf0f0f0f0, 31'h2aaaaaaa), 0, miss});

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (rows[i]) begin
         if (rows[i].known && trace_ray(rows[i].ray) != rows[i].want)
            $display("note: table row %0d disagrees with the predictor", i);
         send_ray(rows[i].ray);
         if (rows[i].known) hit_queue[$] = rows[i].want;
         idle_req();
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         send_ray(rnd_ray());
         if (!long_hold) idle_req();
      end
      req_chan.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // result side: random stalls plus one long hold-off while the input keeps coming
   initial begin
      int unsigned n;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (beats_in >= 300 && !hold_done) begin
            hold_done = 1'b1;
            long_hold = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (200) @(negedge clock);
            long_hold = 1'b0;
         end
         rsp_chan.ready <= 1'b1;
         @(negedge clock);
         n = gap_len();
         if (n != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         beats_out++;
         if (rsp_chan.payload.hit) hits_seen++;
         if (hit_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected rsp beat %p", rsp_chan.payload);
         end else begin
            want = hit_queue.pop_front();
            if (rsp_chan.payload.hit !== want.hit
                  || rsp_chan.payload.distance !== want.distance) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("rsp %0d: expected hit %0b dist %0d, got hit %0b dist %0d",
                           beats_out, want.hit, want.distance,
                           rsp_chan.payload.hit, rsp_chan.payload.distance);
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      while (hit_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      $display("covered %0d rays, %0d results, %0d hits, one long output stall",
               beats_in, beats_out, hits_seen);
      if (mismatches == 0 && hit_queue.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/rsi_pkg.sv
rtl/core/rsi_stream_if.sv
rtl/core/rsi_front.sv
rtl/core/rsi_queue.sv
rtl/core/rsi_back.sv
rtl/core/ray_sphere_intersect.sv
tb/tb_ray_sphere_intersect.sv
